FILE: rtl/atl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atl_pkg
// Shared types, character codes, token codes and helpers of the token lexer.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int ATL_POSITION_BITS = 16;
    localparam int ATL_LENGTH_BITS   = 16;

    localparam int CP_W    = 21;
    localparam int TYPE_W  = 5;
    localparam int FIELD_W = 16;
    localparam int CHARS_W = 35;
    localparam int DIR_COUNT = 7;

    // character codes
    localparam logic [CP_W-1:0] CP_LF     = 21'h0000A;
    localparam logic [CP_W-1:0] CP_SLASH  = 21'h0002F;
    localparam logic [CP_W-1:0] CP_APOS   = 21'h00027;
    localparam logic [CP_W-1:0] CP_QUOTE  = 21'h00022;
    localparam logic [CP_W-1:0] CP_POPEN  = 21'h00028;
    localparam logic [CP_W-1:0] CP_PCLOSE = 21'h00029;
    localparam logic [CP_W-1:0] CP_BOPEN  = 21'h0005B;
    localparam logic [CP_W-1:0] CP_BCLOSE = 21'h0005D;
    localparam logic [CP_W-1:0] CP_SEMI   = 21'h0003B;
    localparam logic [CP_W-1:0] CP_DOT    = 21'h0002E;
    localparam logic [CP_W-1:0] CP_ELOW   = 21'h00065;
    localparam logic [CP_W-1:0] CP_EUP    = 21'h00045;
    localparam logic [CP_W-1:0] CP_PLUS   = 21'h0002B;
    localparam logic [CP_W-1:0] CP_MINUS  = 21'h0002D;

    // token type codes
    localparam logic [TYPE_W-1:0] TT_END     = 5'd0;
    localparam logic [TYPE_W-1:0] TT_COMMENT = 5'd1;
    localparam logic [TYPE_W-1:0] TT_STRING  = 5'd2;
    localparam logic [TYPE_W-1:0] TT_POPEN   = 5'd3;
    localparam logic [TYPE_W-1:0] TT_PCLOSE  = 5'd4;
    localparam logic [TYPE_W-1:0] TT_BOPEN   = 5'd5;
    localparam logic [TYPE_W-1:0] TT_BCLOSE  = 5'd6;
    localparam logic [TYPE_W-1:0] TT_SEMI    = 5'd7;
    localparam logic [TYPE_W-1:0] TT_WORD    = 5'd8;
    localparam logic [TYPE_W-1:0] TT_INT     = 5'd9;
    localparam logic [TYPE_W-1:0] TT_FLOAT   = 5'd10;
    localparam logic [TYPE_W-1:0] TT_DIR_MOD = 5'd11;
    localparam logic [TYPE_W-1:0] TT_TRUE    = 5'd18;
    localparam logic [TYPE_W-1:0] TT_FALSE   = 5'd19;

    // packed 7-bit letters, first letter in the high bits
    localparam logic [27:0] WORD_TRUE  = {7'h74, 7'h72, 7'h75, 7'h65};
    localparam logic [34:0] WORD_FALSE = {7'h66, 7'h61, 7'h6C, 7'h73, 7'h65};
    localparam logic [20:0] DIR_NAMES [DIR_COUNT] = '{
        {7'h6D, 7'h6F, 7'h64},   // mod
        {7'h67, 7'h6C, 7'h62},   // glb
        {7'h6C, 7'h6F, 7'h63},   // loc
        {7'h66, 7'h75, 7'h6E},   // fun
        {7'h61, 7'h72, 7'h67},   // arg
        {7'h72, 7'h65, 7'h67},   // reg
        {7'h62, 7'h6C, 7'h6B}    // blk
    };

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_STRING,
        M_DIRECTIVE,
        M_WORD,
        M_INT,
        M_FRAC,
        M_EXPSTART
    } t_mode;

    typedef struct packed {
        logic [TYPE_W-1:0]  token_type;
        logic [FIELD_W-1:0] start_line;
        logic [FIELD_W-1:0] start_column;
        logic [FIELD_W-1:0] text_length;
        logic               status;
        logic               last;
    } t_token;

    function automatic logic is_alpha(input logic [CP_W-1:0] c);
        return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    endfunction

    function automatic logic is_digit(input logic [CP_W-1:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] c);
        return (c >= 21'h09 && c <= 21'h0D) || c == 21'h20;
    endfunction

    function automatic t_token make_tok(
        input logic [TYPE_W-1:0]  tt,
        input logic [FIELD_W-1:0] ln,
        input logic [FIELD_W-1:0] col,
        input logic [FIELD_W-1:0] len,
        input logic               st,
        input logic               lst
    );
        t_token t;
        t.token_type   = tt;
        t.start_line   = ln;
        t.start_column = col;
        t.text_length  = len;
        t.status       = st;
        t.last         = lst;
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/atl_char_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atl_char_if
// Character channel: one code point or an end-of-input mark per transaction.
// ----------------------------------------------------------------------------
interface atl_char_if
    import atl_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            end_of_input;

    modport source (output valid, output code_point, output end_of_input, input ready);
    modport sink   (input valid, input code_point, input end_of_input, output ready);
endinterface
`default_nettype wire

FILE: rtl/atl_token_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atl_token_if
// Token channel: one finished token per transaction.
// ----------------------------------------------------------------------------
interface atl_token_if
    import atl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TYPE_W-1:0]  token_type;
    logic [FIELD_W-1:0] start_line;
    logic [FIELD_W-1:0] start_column;
    logic [FIELD_W-1:0] text_length;
    logic               status;
    logic               last;

    modport source (output valid, output token_type, output start_line, output start_column,
                     output text_length, output status, output last, input ready);
    modport sink   (input valid, input token_type, input start_line, input start_column,
                     input text_length, input status, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/assembly_token_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// assembly_token_lexer
// Streaming lexer for assembly source, one code point per transaction.
// ----------------------------------------------------------------------------
// The lexer takes one character per clock cycle while i_char.ready is high:
// each accepted character updates the mode, position counters and pending
// token registers. A character can finish one token and start another, so
// up to two tokens are produced per character; they go into a four-entry
// output queue that drains one token per cycle while o_token.ready is high.
// i_char.ready is high while at most two entries are used, so input only
// stalls when the token consumer falls behind. End of input sends the
// pending token and an end marker unless an error was found, then resets.
// ----------------------------------------------------------------------------
module assembly_token_lexer
    import atl_pkg::*;
#(
    parameter int POSITION_BITS = ATL_POSITION_BITS,
    parameter int LENGTH_BITS   = ATL_LENGTH_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    atl_char_if.sink     i_char,
    atl_token_if.source  o_token
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;

    // lexer state
    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic [POSITION_BITS-1:0] r_tline, n_tline;
    logic [POSITION_BITS-1:0] r_tcol, n_tcol;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic                     r_qkind, n_qkind;
    logic                     r_exp, n_exp;
    logic [CHARS_W-1:0]       r_chars, n_chars;
    logic                     r_err, n_err;

    // output queue
    t_token                   r_q [QDEPTH];
    logic [QPTR_W-1:0]        r_wr, r_rd;
    logic [QCNT_W-1:0]        r_cnt;

    logic                     accept;
    logic [CP_W-1:0]          c;

    logic                     fin_has, fin_err;
    logic [TYPE_W-1:0]        fin_type;

    logic [POSITION_BITS-1:0] adv_line, adv_col;
    logic [LENGTH_BITS-1:0]   grow_len;
    logic [CHARS_W-1:0]       grow_chars;

    logic                     cont;
    logic                     f_vld, s_vld;
    t_token                   f_tok, s_tok;
    t_token                   p0, p1;
    logic                     pop;

    assign c      = i_char.code_point;
    assign accept = i_char.valid && i_char.ready;
    assign i_char.ready = (r_cnt <= QCNT_W'(QDEPTH - 2));

    // position and length after taking c
    always_comb begin
        adv_line = r_line;
        adv_col  = r_col;
        if (c == CP_LF) begin
            if (r_line != POS_MAX) adv_line = r_line + 1'b1;
            adv_col = '0;
        end else if (r_col != POS_MAX) begin
            adv_col = r_col + 1'b1;
        end
        grow_len   = (r_len != LEN_MAX) ? r_len + 1'b1 : r_len;
        grow_chars = {r_chars[CHARS_W-8:0], c[6:0]};
    end

    // type of the pending multi-character token
    always_comb begin
        fin_has  = 1'b1;
        fin_err  = 1'b0;
        fin_type = TT_END;
        case (r_mode)
            M_COMMENT: fin_type = TT_COMMENT;
            M_INT:     fin_type = TT_INT;
            M_FRAC, M_EXPSTART: fin_type = TT_FLOAT;
            M_WORD: begin
                fin_type = TT_WORD;
                if (r_len == LENGTH_BITS'(4) && r_chars[27:0] == WORD_TRUE)
                    fin_type = TT_TRUE;
                else if (r_len == LENGTH_BITS'(5) && r_chars == WORD_FALSE)
                    fin_type = TT_FALSE;
            end
            M_DIRECTIVE: begin
                if (r_len == LENGTH_BITS'(4)) begin
                    for (int i = 0; i < DIR_COUNT; i++) begin
                        if (r_chars[20:0] == DIR_NAMES[i])
                            fin_type = TT_DIR_MOD + TYPE_W'(i);
                    end
                end
                fin_err = (fin_type == TT_END);
            end
            default: fin_has = 1'b0;
        endcase
    end

    // character step
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_len   = r_len;
        n_qkind = r_qkind;
        n_exp   = r_exp;
        n_chars = r_chars;
        n_err   = r_err;
        cont    = 1'b0;
        f_vld   = 1'b0;
        s_vld   = 1'b0;
        f_tok   = make_tok(fin_type, FIELD_W'(r_tline), FIELD_W'(r_tcol),
                           FIELD_W'(r_len), 1'b0, 1'b0);
        s_tok   = make_tok(TT_END, FIELD_W'(r_line), FIELD_W'(r_col), '0, 1'b0, 1'b1);

        if (!accept) begin
            cont = 1'b1;
        end else if (i_char.end_of_input) begin
            cont = 1'b1;
            if (!r_err) begin
                if (r_mode == M_STRING || (fin_has && fin_err)) begin
                    f_vld = 1'b1;
                    f_tok = make_tok(TT_END, FIELD_W'(r_tline), FIELD_W'(r_tcol),
                                     '0, 1'b1, 1'b1);
                end else begin
                    f_vld = fin_has;
                    s_vld = 1'b1;
                end
            end
            n_mode  = M_IDLE;
            n_line  = '0;
            n_col   = '0;
            n_tline = '0;
            n_tcol  = '0;
            n_len   = '0;
            n_qkind = 1'b0;
            n_exp   = 1'b0;
            n_chars = '0;
            n_err   = 1'b0;
        end else if (r_err) begin
            cont = 1'b1;
        end else begin
            case (r_mode)
                M_COMMENT: cont = (c != CP_LF);
                M_STRING: begin
                    cont   = 1'b1;
                    n_line = adv_line;
                    n_col  = adv_col;
                    if (c == (r_qkind ? CP_QUOTE : CP_APOS)) begin
                        f_vld  = 1'b1;
                        f_tok  = make_tok(TT_STRING, FIELD_W'(r_tline), FIELD_W'(r_tcol),
                                          FIELD_W'(r_len), 1'b0, 1'b0);
                        n_mode = M_IDLE;
                    end else begin
                        n_len   = grow_len;
                        n_chars = grow_chars;
                    end
                end
                M_DIRECTIVE, M_WORD: cont = is_alpha(c);
                M_INT: begin
                    cont = is_digit(c) || c == CP_DOT;
                    if (c == CP_DOT) begin
                        n_mode = M_FRAC;
                        n_exp  = 1'b0;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        cont = 1'b1;
                    end else if (!r_exp && (c == CP_ELOW || c == CP_EUP)) begin
                        cont   = 1'b1;
                        n_exp  = 1'b1;
                        n_mode = M_EXPSTART;
                    end
                end
                M_EXPSTART: begin
                    cont = is_digit(c) || c == CP_PLUS || c == CP_MINUS;
                    if (cont) n_mode = M_FRAC;
                end
                default: cont = 1'b0;
            endcase

            if (cont && r_mode != M_STRING) begin
                n_line  = adv_line;
                n_col   = adv_col;
                n_len   = grow_len;
                n_chars = grow_chars;
            end

            if (!cont) begin
                if (fin_has && fin_err) begin
                    // unknown directive: error at the dot, character dropped
                    f_vld  = 1'b1;
                    f_tok  = make_tok(TT_END, FIELD_W'(r_tline), FIELD_W'(r_tcol),
                                      '0, 1'b1, 1'b1);
                    n_err  = 1'b1;
                    n_mode = M_IDLE;
                end else begin
                    f_vld  = fin_has;
                    n_mode = M_IDLE;
                    n_line = adv_line;
                    n_col  = adv_col;
                    if (!is_space(c)) begin
                        n_tline = adv_line;
                        n_tcol  = adv_col;
                        n_len   = LENGTH_BITS'(1);
                        n_chars = '0;
                        n_exp   = 1'b0;
                        s_tok   = make_tok(TT_END, FIELD_W'(adv_line), FIELD_W'(adv_col),
                                           FIELD_W'(1), 1'b0, 1'b0);
                        if (c == CP_SLASH) begin
                            n_mode = M_COMMENT;
                        end else if (c == CP_APOS || c == CP_QUOTE) begin
                            n_mode  = M_STRING;
                            n_qkind = (c == CP_QUOTE);
                            n_len   = '0;
                        end else if (c == CP_POPEN) begin
                            s_vld = 1'b1;
                            s_tok.token_type = TT_POPEN;
                        end else if (c == CP_PCLOSE) begin
                            s_vld = 1'b1;
                            s_tok.token_type = TT_PCLOSE;
                        end else if (c == CP_BOPEN) begin
                            s_vld = 1'b1;
                            s_tok.token_type = TT_BOPEN;
                        end else if (c == CP_BCLOSE) begin
                            s_vld = 1'b1;
                            s_tok.token_type = TT_BCLOSE;
                        end else if (c == CP_SEMI) begin
                            s_vld = 1'b1;
                            s_tok.token_type = TT_SEMI;
                        end else if (c == CP_DOT) begin
                            n_mode = M_DIRECTIVE;
                        end else if (is_alpha(c)) begin
                            n_mode  = M_WORD;
                            n_chars = CHARS_W'(c[6:0]);
                        end else if (is_digit(c)) begin
                            n_mode = M_INT;
                        end else begin
                            // bad start character
                            s_vld = 1'b1;
                            s_tok = make_tok(TT_END, FIELD_W'(adv_line), FIELD_W'(adv_col),
                                             '0, 1'b1, 1'b1);
                            n_err = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= '0;
            r_col   <= '0;
            r_tline <= '0;
            r_tcol  <= '0;
            r_len   <= '0;
            r_qkind <= 1'b0;
            r_exp   <= 1'b0;
            r_chars <= '0;
            r_err   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_len   <= n_len;
            r_qkind <= n_qkind;
            r_exp   <= n_exp;
            r_chars <= n_chars;
            r_err   <= n_err;
        end
    end

    // output queue: finished token first, then the one the character started
    assign p0  = f_vld ? f_tok : s_tok;
    assign p1  = s_tok;
    assign pop = o_token.valid && o_token.ready;

    always_ff @(posedge i_clk) begin
        if (f_vld || s_vld)
            r_q[r_wr] <= p0;
        if (f_vld && s_vld)
            r_q[r_wr + 1'b1] <= p1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(f_vld) + QPTR_W'(s_vld);
            r_rd  <= r_rd + QPTR_W'(pop);
            r_cnt <= r_cnt + QCNT_W'(f_vld) + QCNT_W'(s_vld) - QCNT_W'(pop);
        end
    end

    assign o_token.valid        = (r_cnt != '0);
    assign o_token.token_type   = r_q[r_rd].token_type;
    assign o_token.start_line   = r_q[r_rd].start_line;
    assign o_token.start_column = r_q[r_rd].start_column;
    assign o_token.text_length  = r_q[r_rd].text_length;
    assign o_token.status       = r_q[r_rd].status;
    assign o_token.last         = r_q[r_rd].last;

endmodule
`default_nettype wire

FILE: tb/sv/tb_assembly_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_assembly_token_lexer
// Drives source text into the token lexer, one code point per transaction,
// with random idling on both channels. A scoreboard class runs its own lexer
// model on every accepted character and compares each token field by field.
// ----------------------------------------------------------------------------
module tb_assembly_token_lexer;
    import atl_pkg::*;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    localparam logic [CP_W-1:0] CP_TOP     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CH_TAB     = 21'h09;
    localparam logic [CP_W-1:0] CH_SPACE   = 21'h20;
    localparam logic [CP_W-1:0] CH_ZERO    = 21'h30;
    localparam logic [CP_W-1:0] CH_UPPER_A = 21'h41;
    localparam logic [CP_W-1:0] CH_LOWER_A = 21'h61;

    localparam int RANDOM_ITEMS = 800;
    localparam int LONG_RUN     = 32;      // length of the full-rate bursts
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    typedef enum int {
        PK_COMMENT, PK_STRING, PK_PUNCT, PK_WORD, PK_DIRECTIVE, PK_INT, PK_FLOAT
    } t_piece_kind;

    typedef enum int {
        BK_BAD_CHAR, BK_BAD_DIRECTIVE, BK_OPEN_STRING, BK_BAD_EXPONENT
    } t_break_kind;

    // ------------------------------------------------------------------------
    // Token scoreboard: lexer model plus the queue of tokens still owed
    // ------------------------------------------------------------------------
    class token_scoreboard;
        t_token             expected_tokens[$];
        int                 mismatches;
        string              dir_names[DIR_COUNT];

        t_mode              mode;
        logic [FIELD_W-1:0] line_cnt;
        logic [FIELD_W-1:0] col_cnt;
        logic [FIELD_W-1:0] tok_line;
        logic [FIELD_W-1:0] tok_col;
        logic [FIELD_W-1:0] tok_len;
        logic               dquote;
        logic               exp_seen;
        logic               err_latched;
        logic [CHARS_W-1:0] recent_letters;

        function new();
            dir_names  = '{"mod", "glb", "loc", "fun", "arg", "reg", "blk"};
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode           = M_IDLE;
            line_cnt       = '0;
            col_cnt        = '0;
            tok_line       = '0;
            tok_col        = '0;
            tok_len        = '0;
            dquote         = 1'b0;
            exp_seen       = 1'b0;
            err_latched    = 1'b0;
            recent_letters = '0;
        endfunction

        function logic [CHARS_W-1:0] pack_letters(string s);
            logic [CHARS_W-1:0] v = '0;
            byte                b;
            for (int i = 0; i < s.len(); i++) begin
                b = s[i];
                v = {v[CHARS_W-8:0], b[6:0]};
            end
            return v;
        endfunction

        function bit letter_cp(logic [CP_W-1:0] c);
            return c inside {[21'h41:21'h5A], [21'h61:21'h7A]};
        endfunction

        function bit digit_cp(logic [CP_W-1:0] c);
            return c inside {[21'h30:21'h39]};
        endfunction

        function bit blank_cp(logic [CP_W-1:0] c);
            return c inside {[21'h09:21'h0D], 21'h20};
        endfunction

        function void step_position(logic [CP_W-1:0] c);
            if (c == CP_LF) begin
                if (line_cnt != '1)
                    line_cnt++;
                col_cnt = '0;
            end else if (col_cnt != '1) begin
                col_cnt++;
            end
        endfunction

        function void grow_token(logic [CP_W-1:0] c);
            if (tok_len != '1)
                tok_len++;
            recent_letters = {recent_letters[CHARS_W-8:0], c[6:0]};
        endfunction

        function void push(logic [TYPE_W-1:0] tt, logic [FIELD_W-1:0] ln,
                           logic [FIELD_W-1:0] col, logic [FIELD_W-1:0] len,
                           logic st, logic lst);
            t_token t;
            t.token_type   = tt;
            t.start_line   = ln;
            t.start_column = col;
            t.text_length  = len;
            t.status       = st;
            t.last         = lst;
            expected_tokens.push_back(t);
        endfunction

        function void flag_error();
            push(TT_END, tok_line, tok_col, '0, ST_ERROR, 1'b1);
            err_latched = 1'b1;
            mode        = M_IDLE;
        endfunction

        // Emits the pending multi-character token; 0 when it was a bad directive.
        function bit close_token();
            logic [TYPE_W-1:0] tt;
            case (mode)
                M_COMMENT:           tt = TT_COMMENT;
                M_INT:               tt = TT_INT;
                M_FRAC, M_EXPSTART:  tt = TT_FLOAT;
                M_WORD: begin
                    tt = TT_WORD;
                    if (tok_len == 16'd4 && recent_letters[27:0] == 28'(pack_letters("true")))
                        tt = TT_TRUE;
                    else if (tok_len == 16'd5 && recent_letters == pack_letters("false"))
                        tt = TT_FALSE;
                end
                M_DIRECTIVE: begin
                    tt = TT_END;
                    if (tok_len == 16'd4) begin
                        foreach (dir_names[i])
                            if (recent_letters[20:0] == 21'(pack_letters(dir_names[i])))
                                tt = TT_DIR_MOD + TYPE_W'(i);
                    end
                    if (tt == TT_END) begin
                        flag_error();
                        return 1'b0;
                    end
                end
                default: return 1'b1;
            endcase
            push(tt, tok_line, tok_col, tok_len, ST_OK, 1'b0);
            mode = M_IDLE;
            return 1'b1;
        endfunction

        function void take_char(logic [CP_W-1:0] cp, logic eoi);
            if (eoi) begin
                if (!err_latched) begin
                    if (mode == M_STRING)
                        flag_error();
                    else if (close_token())
                        push(TT_END, line_cnt, col_cnt, '0, ST_OK, 1'b1);
                end
                clear_state();
                return;
            end
            if (err_latched)
                return;

            // characters that continue the token being built
            case (mode)
                M_COMMENT:
                    if (cp != CP_LF) begin
                        step_position(cp);
                        grow_token(cp);
                        return;
                    end
                M_STRING: begin
                    step_position(cp);
                    if (cp == (dquote ? CP_QUOTE : CP_APOS)) begin
                        push(TT_STRING, tok_line, tok_col, tok_len, ST_OK, 1'b0);
                        mode = M_IDLE;
                    end else begin
                        grow_token(cp);
                    end
                    return;
                end
                M_DIRECTIVE, M_WORD:
                    if (letter_cp(cp)) begin
                        step_position(cp);
                        grow_token(cp);
                        return;
                    end
                M_INT:
                    if (digit_cp(cp) || cp == CP_DOT) begin
                        step_position(cp);
                        grow_token(cp);
                        if (cp == CP_DOT) begin
                            mode     = M_FRAC;
                            exp_seen = 1'b0;
                        end
                        return;
                    end
                M_FRAC:
                    if (digit_cp(cp) || (!exp_seen && (cp == CP_ELOW || cp == CP_EUP))) begin
                        step_position(cp);
                        grow_token(cp);
                        if (!digit_cp(cp)) begin
                            exp_seen = 1'b1;
                            mode     = M_EXPSTART;
                        end
                        return;
                    end
                M_EXPSTART:
                    if (digit_cp(cp) || cp == CP_PLUS || cp == CP_MINUS) begin
                        step_position(cp);
                        grow_token(cp);
                        mode = M_FRAC;
                        return;
                    end
                default: ;
            endcase

            // the character ends the pending token and may start a new one
            if (!close_token())
                return;
            step_position(cp);
            if (blank_cp(cp))
                return;

            tok_line       = line_cnt;
            tok_col        = col_cnt;
            tok_len        = 16'd1;
            recent_letters = '0;
            exp_seen       = 1'b0;
            case (cp)
                CP_SLASH:  mode = M_COMMENT;
                CP_APOS, CP_QUOTE: begin
                    mode    = M_STRING;
                    dquote  = (cp == CP_QUOTE);
                    tok_len = '0;
                end
                CP_POPEN:  push(TT_POPEN,  tok_line, tok_col, tok_len, ST_OK, 1'b0);
                CP_PCLOSE: push(TT_PCLOSE, tok_line, tok_col, tok_len, ST_OK, 1'b0);
                CP_BOPEN:  push(TT_BOPEN,  tok_line, tok_col, tok_len, ST_OK, 1'b0);
                CP_BCLOSE: push(TT_BCLOSE, tok_line, tok_col, tok_len, ST_OK, 1'b0);
                CP_SEMI:   push(TT_SEMI,   tok_line, tok_col, tok_len, ST_OK, 1'b0);
                CP_DOT:    mode = M_DIRECTIVE;
                default:
                    if (letter_cp(cp)) begin
                        mode           = M_WORD;
                        recent_letters = CHARS_W'(cp);
                    end else if (digit_cp(cp)) begin
                        mode = M_INT;
                    end else begin
                        flag_error();
                    end
            endcase
        endfunction

        function void compare_field(string name, logic [FIELD_W-1:0] want,
                                    logic [FIELD_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_token(t_token got);
            t_token want;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected token, expected none, actual type %0d line %0d",
                         $time, got.token_type, got.start_line);
                $display("    col %0d len %0d status %0b last %0b",
                         got.start_column, got.text_length, got.status, got.last);
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("token_type",   FIELD_W'(want.token_type), FIELD_W'(got.token_type));
            compare_field("start_line",   want.start_line,   got.start_line);
            compare_field("start_column", want.start_column, got.start_column);
            compare_field("text_length",  want.text_length,  got.text_length);
            compare_field("status",       FIELD_W'(want.status),     FIELD_W'(got.status));
            compare_field("last",         FIELD_W'(want.last),       FIELD_W'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    atl_char_if  char_if ();
    atl_token_if tok_if ();

    assembly_token_lexer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_if),
        .o_token (tok_if)
    );

    token_scoreboard sb;
    int  src_calm     = 0;
    int  snk_calm     = 0;
    bit  src_steady   = 1'b0;
    bit  junk         = 1'b0;
    int  stim_items   = 0;
    int  stall_cycles = 0;
    string word_twists[6] = '{"tru", "truex", "False", "fals", "falsey", "TRUE"};

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Random pacing and character helpers
    // ------------------------------------------------------------------------
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 60);
            return 0;
        end
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 1);
    endfunction

    function automatic logic [CP_W-1:0] rand_letter();
        logic [CP_W-1:0] c;
        c = CP_W'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? CH_UPPER_A + c : CH_LOWER_A + c;
    endfunction

    function automatic logic [CP_W-1:0] rand_digit();
        return CH_ZERO + CP_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CP_W-1:0] rand_space();
        int idx;
        idx = $urandom_range(0, 5);
        return (idx == 5) ? CH_SPACE : CH_TAB + CP_W'(idx);
    endfunction

    // anything but the given code point, mostly printable ASCII
    function automatic logic [CP_W-1:0] any_char(logic [CP_W-1:0] excl);
        logic [CP_W-1:0] c;
        case ($urandom_range(0, 3))
            0, 1:    c = CP_W'($urandom_range(21'h20, 21'h7E));
            2:       c = CP_W'($urandom_range(0, 21'h7F));
            default: c = CP_W'($urandom_range(0, CP_TOP));
        endcase
        return (c == excl) ? CH_LOWER_A : c;
    endfunction

    // ------------------------------------------------------------------------
    // Character source
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [CP_W-1:0] cp, input logic eoi);
        int gap;
        gap = src_steady ? 0 : draw_gap(src_calm);
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_if.valid        <= 1'b1;
        char_if.code_point   <= cp;
        char_if.end_of_input <= eoi;
        do @(posedge clk); while (char_if.ready !== 1'b1);
        if (!junk)
            stim_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(CP_W'(s[i]), 1'b0);
    endtask

    task automatic send_eoi();
        send_char(CP_W'($urandom_range(0, CP_TOP)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Token sink
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = draw_gap(snk_calm);
            if (gap > 0) begin
                tok_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tok_if.ready <= 1'b1;
            do @(posedge clk); while (tok_if.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the same edge, input first
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_token got;
        logic   moved;
        if (rst_n) begin
            moved = 1'b0;
            if (char_if.valid === 1'b1 && char_if.ready === 1'b1) begin
                sb.take_char(char_if.code_point, char_if.end_of_input);
                moved = 1'b1;
            end
            if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
                got.token_type   = tok_if.token_type;
                got.start_line   = tok_if.start_line;
                got.start_column = tok_if.start_column;
                got.text_length  = tok_if.text_length;
                got.status       = tok_if.status;
                got.last         = tok_if.last;
                sb.check_token(got);
                moved = 1'b1;
            end
            if (moved) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_piece_kind     kind;
        t_break_kind     brk;
        logic [CP_W-1:0] q;
        int              sep;
        bit              skip_junk;

        sb = new();
        rst_n                <= 1'b0;
        char_if.valid        <= 1'b0;
        char_if.code_point   <= '0;
        char_if.end_of_input <= 1'b0;
        tok_if.ready         <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bad start characters at both ends of the code point range,
        // ignored input after an error, unknown directive, unclosed string,
        // float with signed exponent followed by a second exponent letter
        send_char('0, 1'b0);
        send_text("a");
        send_eoi();
        send_char(CP_TOP, 1'b0);
        send_eoi();
        send_text(".zq;");
        send_eoi();
        send_text("'a\n");
        send_eoi();
        send_text("9.5E-1e");
        send_eoi();

        // random sources, mostly well formed, some ending in a syntax error
        stim_items = 0;
        while (stim_items < RANDOM_ITEMS) begin
            repeat ($urandom_range(1, 24)) begin
                kind = t_piece_kind'($urandom_range(0, 6));
                case (kind)
                    PK_COMMENT: begin
                        send_char(CP_SLASH, 1'b0);
                        repeat ($urandom_range(0, 8)) send_char(any_char(CP_LF), 1'b0);
                        send_char(CP_LF, 1'b0);
                    end
                    PK_STRING: begin
                        q = $urandom_range(0, 1) ? CP_QUOTE : CP_APOS;
                        send_char(q, 1'b0);
                        repeat ($urandom_range(0, 8)) send_char(any_char(q), 1'b0);
                        send_char(q, 1'b0);
                    end
                    PK_PUNCT:
                        case ($urandom_range(0, 4))
                            0:       send_char(CP_POPEN, 1'b0);
                            1:       send_char(CP_PCLOSE, 1'b0);
                            2:       send_char(CP_BOPEN, 1'b0);
                            3:       send_char(CP_BCLOSE, 1'b0);
                            default: send_char(CP_SEMI, 1'b0);
                        endcase
                    PK_WORD:
                        case ($urandom_range(0, 5))
                            0:       send_text("true");
                            1:       send_text("false");
                            2:       send_text(word_twists[$urandom_range(0, 5)]);
                            default: repeat ($urandom_range(1, 9)) send_char(rand_letter(), 1'b0);
                        endcase
                    PK_DIRECTIVE: begin
                        send_char(CP_DOT, 1'b0);
                        send_text(sb.dir_names[$urandom_range(0, DIR_COUNT - 1)]);
                    end
                    PK_INT:
                        repeat ($urandom_range(1, 6)) send_char(rand_digit(), 1'b0);
                    default: begin
                        repeat ($urandom_range(1, 4)) send_char(rand_digit(), 1'b0);
                        send_char(CP_DOT, 1'b0);
                        repeat ($urandom_range(0, 4)) send_char(rand_digit(), 1'b0);
                        if ($urandom_range(0, 1)) begin
                            send_char($urandom_range(0, 1) ? CP_ELOW : CP_EUP, 1'b0);
                            case ($urandom_range(0, 2))
                                0:       ;
                                1:       send_char(CP_PLUS, 1'b0);
                                default: send_char(CP_MINUS, 1'b0);
                            endcase
                            repeat ($urandom_range(0, 3)) send_char(rand_digit(), 1'b0);
                        end
                    end
                endcase

                // a directive followed by letters would turn into an unknown one
                sep = $urandom_range(0, 5);
                if (kind == PK_DIRECTIVE && sep < 2)
                    sep = 2;
                case (sep)
                    0, 1: ;
                    2:       send_char(CH_SPACE, 1'b0);
                    3:       send_char(CP_LF, 1'b0);
                    default: repeat ($urandom_range(1, 3)) send_char(rand_space(), 1'b0);
                endcase
            end

            if ($urandom_range(0, 3) == 0) begin
                skip_junk = 1'b0;
                brk = t_break_kind'($urandom_range(0, 3));
                case (brk)
                    BK_BAD_CHAR:
                        case ($urandom_range(0, 3))
                            0:       send_char(CP_W'($urandom_range(21'h80, CP_TOP)), 1'b0);
                            1:       send_char(CP_W'($urandom_range(0, 21'h08)), 1'b0);
                            2:       send_char($urandom_range(0, 1) ? CP_PLUS : CP_MINUS, 1'b0);
                            default: send_char(CP_W'($urandom_range(21'h21, 21'h7E)), 1'b0);
                        endcase
                    BK_BAD_DIRECTIVE: begin
                        send_char(CP_DOT, 1'b0);
                        repeat ($urandom_range(1, 4)) send_char(rand_letter(), 1'b0);
                    end
                    BK_OPEN_STRING: begin
                        q = $urandom_range(0, 1) ? CP_QUOTE : CP_APOS;
                        send_char(q, 1'b0);
                        repeat ($urandom_range(0, 5)) send_char(any_char(q), 1'b0);
                        skip_junk = 1'b1;
                    end
                    default: send_text("1.e+-");
                endcase
                if (!skip_junk) begin
                    junk = 1'b1;
                    repeat ($urandom_range(0, 3)) send_char(any_char(CP_LF), 1'b0);
                    junk = 1'b0;
                end
            end
            send_eoi();
        end

        // one source at full rate: a long string, then a run of line feeds
        src_steady = 1'b1;
        send_char(CP_APOS, 1'b0);
        repeat (LONG_RUN) send_char(rand_letter(), 1'b0);
        send_char(CP_APOS, 1'b0);
        send_char(CP_SEMI, 1'b0);
        repeat (LONG_RUN) send_char(CP_LF, 1'b0);
        send_text("7");
        send_eoi();
        src_steady = 1'b0;

        char_if.valid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
